@@ hdl/cprc_pkg.sv @@
// Shared constants, codes and types of the polar/rectangular conversion core.
`default_nettype none

package cprc_pkg;

    localparam int DATA_WIDTH_DEF     = 16;
    localparam int ROTATION_STEPS_DEF = 16;
    localparam int MAX_STEPS          = 32;

    // Port word layout.
    localparam int OPND_W    = 16;
    localparam int RES1_W    = 17;
    localparam int RES2_W    = 16;
    localparam int S_TDATA_W = 2 * OPND_W;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - RES1_W - RES2_W;

    // Coordinates carry the guard bits plus this much integer headroom.
    localparam int GROWTH_BITS = 19;
    // Angle accumulator, Q2.30 radians with headroom for the table sum.
    localparam int ZW        = 35;
    localparam int ANG_W     = 17;
    localparam int ANG_SHIFT = 17;
    localparam int MAG_W     = 19;

    localparam logic signed [ZW-1:0]    PI_Q30     = 35'sd3373259426;
    localparam logic signed [ZW-1:0]    Z_ROUND    = 35'sd65536;
    localparam logic signed [RES2_W-1:0] PI_Q13    = 16'sd25736;
    localparam logic signed [ANG_W-1:0] PI_Q13_W   = 17'sd25736;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q13 = 17'sd51472;
    // Largest Q3.13 angle that still lies within plus or minus pi/2 in Q2.30.
    localparam logic signed [ANG_W-1:0] FOLD_Q13   = 17'sd12867;

    localparam logic signed [RES1_W-1:0] MAG_MAX   = 17'sd46341;
    localparam int Y_POS_MAX = 32767;
    localparam int Y_NEG_MAX = 32768;

    // 1/K of the rotation gain, as a 32-bit fraction.
    localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

    // atan(2^-i) in Q2.30, truncated.
    localparam logic [29:0] ATAN_TAB [MAX_STEPS] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    typedef enum logic {
        KIND_RECT_TO_POLAR = 1'b0,
        KIND_POLAR_TO_RECT = 1'b1
    } cprc_kind_t;

    typedef struct packed {
        logic vectoring;  // drive y to zero (rectangular to polar)
        logic zero;       // zero input vector, force a zero result
    } cprc_flags_t;

endpackage

`default_nettype wire

@@ hdl/complex_polar_rect_convert_core.sv @@
// Top level of the pipelined CORDIC polar/rectangular conversion core.
//
// Converts one complex word per clock, unless the output stalls, between
// rectangular and polar form. With s_tuser low, (re, im) becomes (magnitude,
// atan2 angle in Q3.13 radians); with s_tuser high, (magnitude, angle) becomes
// (re, im), the angle first wrapped into [-pi, pi]. Every stage holds its own
// valid bit and moves on when the next stage has room, so a new word is taken
// each cycle unless the output stalls, and bubbles close up during an output
// stall. There are two input stages, one stage per micro-rotation (at most 32)
// and four stages for gain compensation, rounding and saturation.
`default_nettype none

module complex_polar_rect_convert_core
    import cprc_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // first_operand, second_operand
    input  logic [0:0]           s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // first_result, second_result, zero pad
);

    localparam int XW    = DATA_WIDTH + GROWTH_BITS;
    localparam int STEPS = (ROTATION_STEPS > MAX_STEPS) ? MAX_STEPS : ROTATION_STEPS;

    logic                 rv [STEPS+1];
    logic                 rr [STEPS+1];
    logic signed [XW-1:0] rx [STEPS+1];
    logic signed [XW-1:0] ry [STEPS+1];
    logic signed [ZW-1:0] rz [STEPS+1];
    cprc_flags_t          rf [STEPS+1];

    logic signed [RES1_W-1:0] first_result;
    logic signed [RES2_W-1:0] second_result;

    cprc_prep #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (cprc_kind_t'(s_tuser[0])),
        .in_first  (s_tdata[OPND_W-1:0]),
        .in_second (s_tdata[S_TDATA_W-1:OPND_W]),
        .out_valid (rv[0]),
        .out_ready (rr[0]),
        .out_x     (rx[0]),
        .out_y     (ry[0]),
        .out_z     (rz[0]),
        .out_flags (rf[0])
    );

    for (genvar k = 0; k < STEPS; k++) begin : g_rot
        cprc_rot_stage #(
            .DATA_WIDTH(DATA_WIDTH),
            .STEP      (k)
        ) u_rot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (rv[k]),
            .in_ready  (rr[k]),
            .in_x      (rx[k]),
            .in_y      (ry[k]),
            .in_z      (rz[k]),
            .in_flags  (rf[k]),
            .out_valid (rv[k+1]),
            .out_ready (rr[k+1]),
            .out_x     (rx[k+1]),
            .out_y     (ry[k+1]),
            .out_z     (rz[k+1]),
            .out_flags (rf[k+1])
        );
    end

    cprc_post #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rv[STEPS]),
        .in_ready   (rr[STEPS]),
        .in_x       (rx[STEPS]),
        .in_y       (ry[STEPS]),
        .in_z       (rz[STEPS]),
        .in_flags   (rf[STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_first  (first_result),
        .out_second (second_result)
    );

    assign m_tdata = {M_PAD_W'(0), second_result, first_result};

endmodule

`default_nettype wire

@@ hdl/cprc_prep.sv @@
// Input stages: angle wrap, quadrant fold and start values of the rotation pipeline.
`default_nettype none

module cprc_prep
    import cprc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int XW = DATA_WIDTH + GROWTH_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cprc_kind_t               in_kind,
    input  logic signed [OPND_W-1:0] in_first,
    input  logic signed [OPND_W-1:0] in_second,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [XW-1:0]     out_x,
    output logic signed [XW-1:0]     out_y,
    output logic signed [ZW-1:0]     out_z,
    output cprc_flags_t              out_flags
);

    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     s1_ready;
    logic                     s2_ready;

    cprc_kind_t               s1_kind_reg;
    logic signed [OPND_W-1:0] s1_first_reg;
    logic signed [ANG_W-1:0]  s1_ang_reg;
    logic                     s1_zero_reg;
    logic                     s1_up_reg;
    logic                     s1_dn_reg;

    logic signed [ANG_W-1:0]  b_ext;
    logic signed [ANG_W-1:0]  wrapped;
    logic signed [ANG_W-1:0]  ang_next;
    logic                     zero_next;
    logic                     up_next;
    logic                     dn_next;

    logic signed [ANG_W-1:0]  a_ext;
    logic signed [ANG_W-1:0]  a_neg;
    logic signed [ZW-1:0]     z_base;
    logic signed [XW-1:0]     x_next;
    logic signed [XW-1:0]     y_next;
    logic signed [ZW-1:0]     z_next;
    cprc_flags_t              flags_next;

    logic signed [XW-1:0]     x_reg;
    logic signed [XW-1:0]     y_reg;
    logic signed [ZW-1:0]     z_reg;
    cprc_flags_t              flags_reg;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: wrap the angle into [-pi, pi] and decide the half-plane fold.
    always_comb begin
        b_ext = ANG_W'(in_second);
        if (b_ext > PI_Q13_W) begin
            wrapped = b_ext - TWO_PI_Q13;
        end else if (b_ext < -PI_Q13_W) begin
            wrapped = b_ext + TWO_PI_Q13;
        end else begin
            wrapped = b_ext;
        end
        ang_next  = (in_kind == KIND_POLAR_TO_RECT) ? wrapped : b_ext;
        up_next   = wrapped > FOLD_Q13;
        dn_next   = wrapped < -FOLD_Q13;
        zero_next = (in_kind == KIND_RECT_TO_POLAR) && (in_first == '0) && (in_second == '0);
    end

    // Stage 2: build x, y and z; turn left half-plane vectors by pi.
    always_comb begin
        a_ext  = ANG_W'(s1_first_reg);
        a_neg  = -a_ext;
        z_base = ZW'(s1_ang_reg) <<< ANG_SHIFT;
        x_next = '0;
        y_next = '0;
        z_next = '0;
        flags_next.vectoring = 1'b0;
        flags_next.zero      = s1_zero_reg;
        case (s1_kind_reg)
            KIND_RECT_TO_POLAR: begin
                flags_next.vectoring = 1'b1;
                if (s1_first_reg[OPND_W-1]) begin
                    x_next = XW'(a_neg) <<< DATA_WIDTH;
                    y_next = XW'(-s1_ang_reg) <<< DATA_WIDTH;
                    z_next = s1_ang_reg[ANG_W-1] ? -PI_Q30 : PI_Q30;
                end else begin
                    x_next = XW'(a_ext) <<< DATA_WIDTH;
                    y_next = XW'(s1_ang_reg) <<< DATA_WIDTH;
                end
            end
            KIND_POLAR_TO_RECT: begin
                if (s1_up_reg) begin
                    x_next = XW'(a_neg) <<< DATA_WIDTH;
                    z_next = z_base - PI_Q30;
                end else if (s1_dn_reg) begin
                    x_next = XW'(a_neg) <<< DATA_WIDTH;
                    z_next = z_base + PI_Q30;
                end else begin
                    x_next = XW'(a_ext) <<< DATA_WIDTH;
                    z_next = z_base;
                end
            end
            default: begin
                x_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_kind_reg  <= in_kind;
            s1_first_reg <= in_first;
            s1_ang_reg   <= ang_next;
            s1_zero_reg  <= zero_next;
            s1_up_reg    <= up_next;
            s1_dn_reg    <= dn_next;
        end
        if (s2_ready && s1_valid_reg) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

@@ hdl/cprc_rot_stage.sv @@
// One registered micro-rotation of the CORDIC pipeline.
`default_nettype none

module cprc_rot_stage
    import cprc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int STEP = 0,
    localparam int XW = DATA_WIDTH + GROWTH_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  logic signed [ZW-1:0] in_z,
    input  cprc_flags_t          in_flags,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [XW-1:0] out_x,
    output logic signed [XW-1:0] out_y,
    output logic signed [ZW-1:0] out_z,
    output cprc_flags_t          out_flags
);

    localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_TAB[STEP]);

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    cprc_flags_t          flags_reg;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 turn_cw;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    assign in_ready = !valid_reg || out_ready;

    // Vectoring steers on the sign of y, rotation on the sign of z.
    always_comb begin
        dx      = in_y >>> STEP;
        dy      = in_x >>> STEP;
        turn_cw = in_flags.vectoring ? !in_y[XW-1] : in_z[ZW-1];
        if (turn_cw) begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ANGLE;
        end else begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

@@ hdl/cprc_post.sv @@
// Output stages: gain compensation, rounding, angle scaling and saturation.
`default_nettype none

module cprc_post
    import cprc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int XW = DATA_WIDTH + GROWTH_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [XW-1:0]     in_x,
    input  logic signed [XW-1:0]     in_y,
    input  logic signed [ZW-1:0]     in_z,
    input  cprc_flags_t              in_flags,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [RES1_W-1:0] out_first,
    output logic signed [RES2_W-1:0] out_second
);

    localparam int UHW = (XW > 32) ? XW - 32 : 1;
    localparam int UPW = 32 + UHW;
    localparam logic [UPW:0]         HALF_LSB  = (UPW + 1)'(1) << (DATA_WIDTH - 1);
    localparam logic signed [ZW-1:0] ZPI       = ZW'(PI_Q13);
    localparam logic [MAG_W-1:0]     MAG_LIM   = MAG_W'(MAG_MAX);
    localparam logic [MAG_W-1:0]     Y_POS_LIM = MAG_W'(Y_POS_MAX);
    localparam logic [MAG_W-1:0]     Y_NEG_LIM = MAG_W'(Y_NEG_MAX);

    logic abs_valid_reg, mul_valid_reg, sum_valid_reg, out_valid_reg;
    logic abs_rdy, mul_rdy, sum_rdy, out_rdy;

    // Stage A: sign and magnitude, angle to Q3.13.
    logic signed [ZW-1:0]     z_round;
    logic [XW-1:0]            xmag_next;
    logic [XW-1:0]            ymag_next;
    logic signed [RES2_W-1:0] ang_next;
    cprc_flags_t              abs_flags_reg;
    logic                     abs_xneg_reg, abs_yneg_reg;
    logic [XW-1:0]            abs_xmag_reg, abs_ymag_reg;
    logic signed [RES2_W-1:0] abs_ang_reg;

    // Stage B: partial products of the gain multiply.
    logic [UPW-1:0]           ux, uy;
    logic [63:0]              xlo_prod, ylo_prod;
    logic [UPW-1:0]           xhi_next, yhi_next;
    cprc_flags_t              mul_flags_reg;
    logic                     mul_xneg_reg, mul_yneg_reg;
    logic [UPW-1:0]           mul_xhi_reg, mul_yhi_reg;
    logic [31:0]              mul_xlo_reg, mul_ylo_reg;
    logic signed [RES2_W-1:0] mul_ang_reg;

    // Stage C: sum, round half away from zero and drop the guard bits.
    logic [UPW:0]             xsum, ysum;
    cprc_flags_t              sum_flags_reg;
    logic                     sum_xneg_reg, sum_yneg_reg;
    logic [MAG_W-1:0]         sum_xmag_reg, sum_ymag_reg;
    logic signed [RES2_W-1:0] sum_ang_reg;

    // Stage D: saturate, restore sign, select.
    logic [MAG_W-1:0]         m1, m2, y_lim, f1, f2;
    logic signed [RES1_W-1:0] first_next;
    logic signed [RES2_W-1:0] second_next;
    logic signed [RES1_W-1:0] first_reg;
    logic signed [RES2_W-1:0] second_reg;

    assign out_rdy  = !out_valid_reg || out_ready;
    assign sum_rdy  = !sum_valid_reg || out_rdy;
    assign mul_rdy  = !mul_valid_reg || sum_rdy;
    assign abs_rdy  = !abs_valid_reg || mul_rdy;
    assign in_ready = abs_rdy;

    always_comb begin
        xmag_next = in_x[XW-1] ? XW'(-in_x) : XW'(in_x);
        ymag_next = in_y[XW-1] ? XW'(-in_y) : XW'(in_y);
        z_round   = (in_z + Z_ROUND) >>> ANG_SHIFT;
        // An angle above plus pi, or at or below minus pi, is reported as plus pi.
        if (z_round > ZPI || z_round <= -ZPI) begin
            ang_next = PI_Q13;
        end else begin
            ang_next = RES2_W'(z_round);
        end
    end

    always_comb begin
        ux       = UPW'(abs_xmag_reg);
        uy       = UPW'(abs_ymag_reg);
        xhi_next = UPW'(ux[UPW-1:32]) * UPW'(INV_GAIN);
        yhi_next = UPW'(uy[UPW-1:32]) * UPW'(INV_GAIN);
        xlo_prod = 64'(ux[31:0]) * 64'(INV_GAIN);
        ylo_prod = 64'(uy[31:0]) * 64'(INV_GAIN);
    end

    always_comb begin
        xsum = (UPW + 1)'(mul_xhi_reg) + (UPW + 1)'(mul_xlo_reg) + HALF_LSB;
        ysum = (UPW + 1)'(mul_yhi_reg) + (UPW + 1)'(mul_ylo_reg) + HALF_LSB;
    end

    always_comb begin
        m1    = (sum_xmag_reg > MAG_LIM) ? MAG_LIM : sum_xmag_reg;
        f1    = sum_xneg_reg ? -m1 : m1;
        y_lim = sum_yneg_reg ? Y_NEG_LIM : Y_POS_LIM;
        m2    = (sum_ymag_reg > y_lim) ? y_lim : sum_ymag_reg;
        f2    = sum_yneg_reg ? -m2 : m2;
        if (sum_flags_reg.zero) begin
            first_next  = '0;
            second_next = '0;
        end else begin
            first_next  = RES1_W'(f1);
            second_next = sum_flags_reg.vectoring ? sum_ang_reg : RES2_W'(f2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (abs_rdy) begin
                abs_valid_reg <= in_valid;
            end
            if (mul_rdy) begin
                mul_valid_reg <= abs_valid_reg;
            end
            if (sum_rdy) begin
                sum_valid_reg <= mul_valid_reg;
            end
            if (out_rdy) begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (abs_rdy && in_valid) begin
            abs_flags_reg <= in_flags;
            abs_xneg_reg  <= in_x[XW-1];
            abs_yneg_reg  <= in_y[XW-1];
            abs_xmag_reg  <= xmag_next;
            abs_ymag_reg  <= ymag_next;
            abs_ang_reg   <= ang_next;
        end
        if (mul_rdy && abs_valid_reg) begin
            mul_flags_reg <= abs_flags_reg;
            mul_xneg_reg  <= abs_xneg_reg;
            mul_yneg_reg  <= abs_yneg_reg;
            mul_xhi_reg   <= xhi_next;
            mul_yhi_reg   <= yhi_next;
            mul_xlo_reg   <= xlo_prod[63:32];
            mul_ylo_reg   <= ylo_prod[63:32];
            mul_ang_reg   <= abs_ang_reg;
        end
        if (sum_rdy && mul_valid_reg) begin
            sum_flags_reg <= mul_flags_reg;
            sum_xneg_reg  <= mul_xneg_reg;
            sum_yneg_reg  <= mul_yneg_reg;
            sum_xmag_reg  <= xsum[DATA_WIDTH +: MAG_W];
            sum_ymag_reg  <= ysum[DATA_WIDTH +: MAG_W];
            sum_ang_reg   <= mul_ang_reg;
        end
        if (out_rdy && sum_valid_reg) begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;

endmodule

`default_nettype wire

@@ hdl/cprc_checker.sv @@
// Port-level checks of the conversion core, bound to its top level.
`default_nettype none

module cprc_checker
    import cprc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_free_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input held off while the output side has room");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[RES1_W-1:0]) <= MAG_MAX
                      && $signed(m_tdata[RES1_W-1:0]) >= -MAG_MAX))
        else $error("first result outside its saturation range");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && s_tvalid |-> m_tdata[M_TDATA_W-1:RES1_W+RES2_W] == '0)
        else $error("pad bits of the output word not zero");

endmodule

bind complex_polar_rect_convert_core cprc_checker u_cprc_checker (.*);

`default_nettype wire

@@ sim/complex_polar_rect_convert_core_tb.sv @@
// Self-checking testbench for the pipelined CORDIC polar/rectangular conversion core.
`timescale 1ns / 100ps

module complex_polar_rect_convert_core_tb;
    import cprc_pkg::*;

    localparam int    GUARD_BITS  = DATA_WIDTH_DEF;
    localparam int    ROT_STEPS   = ROTATION_STEPS_DEF;
    localparam int    STEPS_RUN   = (ROT_STEPS > 32) ? 32 : ROT_STEPS;
    localparam int    LATENCY     = ROT_STEPS + 6;
    localparam int    N_RANDOM    = 1800;
    localparam int    CALM_TAIL   = 150;
    localparam int    LONG_HOLD   = 200;
    localparam int    STALL_LIMIT = 4000;

    localparam longint UNIT_SCALE   = 64'sd1 <<< GUARD_BITS;
    localparam longint PI_FINE      = 64'sd3373259426;
    localparam longint HALF_PI_FINE = 64'sd1686629713;
    localparam longint PI_COARSE    = 64'sd25736;
    localparam longint TWO_PI_COARSE = 64'sd51472;
    localparam longint MAG_LIMIT    = 64'sd46341;
    localparam longint unsigned GAIN_RECIP = 64'h0000_0000_9B74_EDA8;

    // atan(2^-i), Q2.30 radians, truncated
    localparam longint ANGLE_STEP [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1, 0, 0
    };

    typedef struct {
        cprc_kind_t          kind;
        logic signed [15:0]  opnd_a;
        logic signed [15:0]  opnd_b;
    } conv_item_t;

    typedef struct {
        logic signed [16:0]  first_result;
        logic signed [15:0]  second_result;
    } conv_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // first_operand, second_operand
    logic [0:0]           s_tuser  = '0;   // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // first_result, second_result, zero pad

    conv_item_t   conversions_pending[$];
    conv_result_t results_due[$];

    bit in_fire, out_fire;
    int n_accepted, n_rect, n_polar, n_checked, n_errors, n_directed;
    int stall_cycles;

    complex_polar_rect_convert_core #(
        .DATA_WIDTH    (GUARD_BITS),
        .ROTATION_STEPS(ROT_STEPS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Scale by 1/K and drop the guard bits, rounding half away from zero.
    function automatic longint gain_fix(longint v);
        bit neg;
        longint unsigned u, hi, lo, p, r;
        neg = (v < 0);
        u   = neg ? longint'(-v) : v;
        hi  = u >> 32;
        lo  = u & 64'hFFFF_FFFF;
        p   = hi * GAIN_RECIP + ((lo * GAIN_RECIP) >> 32);
        r   = (p + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic conv_result_t predict_conversion(cprc_kind_t kind,
                                                        logic signed [15:0] a16,
                                                        logic signed [15:0] b16);
        conv_result_t res;
        longint a, b, x, y, z, dx, dy, ang, r0, r1;
        int i;
        a = a16;
        b = b16;
        if (kind == KIND_RECT_TO_POLAR) begin
            if (a == 0 && b == 0) begin
                r0 = 0;
                r1 = 0;
            end else begin
                x = a * UNIT_SCALE;
                y = b * UNIT_SCALE;
                z = 0;
                // left half-plane: turn by pi first
                if (x < 0) begin
                    x = -x;
                    y = -y;
                    z = (b >= 0) ? PI_FINE : -PI_FINE;
                end
                for (i = 0; i < STEPS_RUN; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0) begin
                        x += dx; y -= dy; z += ANGLE_STEP[i];
                    end else begin
                        x -= dx; y += dy; z -= ANGLE_STEP[i];
                    end
                end
                r0 = clip(gain_fix(x), -MAG_LIMIT, MAG_LIMIT);
                r1 = (z + 64'sd65536) >>> 17;
                if (r1 > PI_COARSE || r1 <= -PI_COARSE)
                    r1 = PI_COARSE;
            end
        end else begin
            ang = b;
            if (ang > PI_COARSE)
                ang -= TWO_PI_COARSE;
            else if (ang < -PI_COARSE)
                ang += TWO_PI_COARSE;
            z = ang * 131072;
            x = a * UNIT_SCALE;
            y = 0;
            // fold into the right half-plane
            if (z > HALF_PI_FINE) begin
                x = -x; z -= PI_FINE;
            end else if (z < -HALF_PI_FINE) begin
                x = -x; z += PI_FINE;
            end
            for (i = 0; i < STEPS_RUN; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ANGLE_STEP[i];
                end else begin
                    x += dx; y -= dy; z += ANGLE_STEP[i];
                end
            end
            r0 = clip(gain_fix(x), -MAG_LIMIT, MAG_LIMIT);
            r1 = clip(gain_fix(y), -64'sd32768, 64'sd32767);
        end
        res.first_result  = r0[16:0];
        res.second_result = r1[15:0];
        return res;
    endfunction

    function automatic bit take_break(int rate);
        case (rate)
            1:       return $urandom_range(0, 7) == 0;
            2:       return $urandom_range(0, 2) == 0;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_operand();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = -16'sd32768;
                    1:       v = 16'sd32767;
                    2:       v = 16'sd0;
                    3:       v = -16'sd1;
                    default: v = 16'sd1;
                endcase
            end
            1, 2: v = 16'($urandom_range(0, 128) - 64);
            3: begin
                // near the wrap and fold points of the angle
                v = $urandom_range(0, 1) ? 16'(25736 + $urandom_range(0, 4) - 2)
                                         : 16'(12867 + $urandom_range(0, 4) - 2);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    function automatic conv_item_t make_item(cprc_kind_t kind, int a, int b);
        conv_item_t it;
        it.kind   = kind;
        it.opnd_a = 16'(a);
        it.opnd_b = 16'(b);
        return it;
    endfunction

    // Sample both channels, predict on input, check on output.
    always @(posedge aclk) begin : monitor
        conv_result_t exp_res, got;
        in_fire  = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        if (in_fire) begin
            results_due.push_back(predict_conversion(cprc_kind_t'(s_tuser[0]),
                                                     s_tdata[15:0], s_tdata[31:16]));
            n_accepted++;
            if (s_tuser[0] == KIND_RECT_TO_POLAR)
                n_rect++;
            else
                n_polar++;
        end
        if (out_fire) begin
            got.first_result  = m_tdata[16:0];
            got.second_result = m_tdata[32:17];
            if (results_due.size() == 0) begin
                $error("unexpected result word: first_result %0d, second_result %0d",
                       got.first_result, got.second_result);
                n_errors++;
            end else begin
                exp_res = results_due.pop_front();
                if (got.first_result !== exp_res.first_result) begin
                    $error("first_result mismatch: expected %0d, actual %0d",
                           exp_res.first_result, got.first_result);
                    n_errors++;
                end
                if (got.second_result !== exp_res.second_result) begin
                    $error("second_result mismatch: expected %0d, actual %0d",
                           exp_res.second_result, got.second_result);
                    n_errors++;
                end
                n_checked++;
            end
        end
        if (aresetn && !in_fire && !out_fire &&
            (conversions_pending.size() != 0 || results_due.size() != 0 || s_tvalid))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles, %0d results outstanding",
                   stall_cycles, results_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Input driver: hold the word until taken, then advance or idle.
    int in_gap, in_rate, in_seg;
    always @(negedge aclk) begin : drive_input
        conv_item_t it;
        bit calm;
        calm = (n_accepted >= n_directed + N_RANDOM - CALM_TAIL);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            in_seg++;
            if (in_seg % 128 == 0)
                in_rate = $urandom_range(0, 2);
            if (!s_tvalid || in_fire) begin
                if (in_gap > 0 && !calm) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (!calm && take_break(in_rate)) begin
                    in_gap = $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end else if (conversions_pending.size() != 0) begin
                    it = conversions_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {it.opnd_b, it.opnd_a};
                    s_tuser  <= it.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random bursts of backpressure plus one long hold.
    int out_gap, out_rate, out_seg, long_left;
    bit long_done;
    always @(negedge aclk) begin : drive_ready
        bit calm;
        calm = (n_accepted >= n_directed + N_RANDOM - CALM_TAIL);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            out_seg++;
            if (out_seg % 128 == 0)
                out_rate = $urandom_range(0, 2);
            if (long_left > 0) begin
                long_left--;
                m_tready <= 1'b0;
            end else if (!long_done && n_checked >= 300) begin
                long_done = 1'b1;
                long_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (out_gap > 0 && !calm) begin
                out_gap--;
                m_tready <= 1'b0;
            end else if (!calm && take_break(out_rate)) begin
                out_gap = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        cprc_kind_t k;
        int half;
        // rectangular to polar: zero vector, axes, corners, left half-plane
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, 0, 0));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, 32767, 0));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, -32768, 0));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, -1, 0));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, 0, 32767));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, 0, -32768));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, 32767, 32767));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, -32768, -32768));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, -32768, 32767));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, 32767, -32768));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, -5, -1));
        conversions_pending.push_back(make_item(KIND_RECT_TO_POLAR, 1, 1));
        // polar to rectangular: pi edges, wrap, fold, negative magnitude
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, 32767, 0));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, 32767, 25736));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, 32767, -25736));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, 32767, 25737));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, 32767, -25737));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, 32767, 32767));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, -32768, -32768));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, 32767, 12867));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, -32768, 12868));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, -32768, -12868));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, -32768, 12867));
        conversions_pending.push_back(make_item(KIND_POLAR_TO_RECT, 0, 100));
        n_directed = conversions_pending.size();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        half = N_RANDOM / 2;
        for (int p = 0; p < 2; p++) begin
            // drain fully before the next batch: sender pause
            while (conversions_pending.size() != 0 || results_due.size() != 0 || s_tvalid)
                @(posedge aclk);
            for (int n = 0; n < half; n++) begin
                k = $urandom_range(0, 1) ? KIND_POLAR_TO_RECT : KIND_RECT_TO_POLAR;
                conversions_pending.push_back('{k, pick_operand(), pick_operand()});
            end
        end

        while (conversions_pending.size() != 0 || results_due.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            n_errors++;
        end

        $display("Converted %0d words (%0d rectangular-to-polar, %0d polar-to-rectangular),",
                 n_accepted, n_rect, n_polar);
        $display("%0d results checked under random stalls and a %0d-cycle output hold",
                 n_checked, LONG_HOLD);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/cprc_pkg.sv
hdl/cprc_prep.sv
hdl/cprc_rot_stage.sv
hdl/cprc_post.sv
hdl/complex_polar_rect_convert_core.sv
hdl/cprc_checker.sv
sim/complex_polar_rect_convert_core_tb.sv
